### sv/glsq_pkg.sv
// Shared types, constants and arithmetic helpers of the Givens QR least-squares block.
`default_nettype none
package glsq_pkg;

   localparam int MAX_UNKNOWNS = 8;
   localparam int VALUE_BITS   = 32;
   localparam int IDX_W        = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
   localparam int CNT_W        = $clog2(MAX_UNKNOWNS + 1);
   localparam int ADDR_W       = 2 * IDX_W;
   localparam int TRI_DEPTH    = MAX_UNKNOWNS * MAX_UNKNOWNS;
   localparam int QUEUE_DEPTH  = 2;
   localparam int ORDER_W      = 4;
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd8;

   localparam logic signed [63:0] VMAX64 = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

   typedef enum logic [1:0] {
      ACT_ELEM  = 2'd0,
      ACT_OBS   = 2'd1,
      ACT_SOLVE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic {
      KIND_RESIDUAL = 1'b0,
      KIND_COEFF    = 1'b1
   } kind_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         column;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [2:0]         index;
      logic signed [31:0] result_value;
      logic               last;
      logic               singular;
   } rsp_type;

   typedef struct packed {
      action_type         action;
      logic               col_ok;
      logic [2:0]         column;
      logic signed [31:0] value;
   } op_type;

   typedef struct packed {
      logic        start;
      logic        is_root;
      logic [63:0] num;
      logic [31:0] den;
   } ru_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ru_stat_type;

   function automatic logic signed [VALUE_BITS-1:0] sat_value(input logic signed [63:0] v);
      logic signed [VALUE_BITS-1:0] r;
      if (v > VMAX64) begin
         r = VMAX64[VALUE_BITS-1:0];
      end else if (v < VMIN64) begin
         r = VMIN64[VALUE_BITS-1:0];
      end else begin
         r = v[VALUE_BITS-1:0];
      end
      return r;
   endfunction

   // Divide by 2^sh, rounding half up (floor of p/2^sh + 1/2).
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] p, input int sh);
      logic signed [63:0] half;
      half = 64'sd1 <<< (sh - 1);
      return (p + half) >>> sh;
   endfunction

   function automatic logic [31:0] abs_value(input logic signed [31:0] v);
      logic signed [31:0] n;
      n = -v;
      return v[31] ? 32'(n) : 32'(v);
   endfunction

endpackage
`default_nettype wire

### sv/glsq_front.sv
// Front end: stages an accepted item and classifies it into a queue entry.
`default_nettype none
module glsq_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire glsq_pkg::req_type  req_data,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output glsq_pkg::op_type        push_data
);

   logic             pend_vld_ff, pend_vld_in;
   glsq_pkg::op_type pend_ff, pend_in;
   logic             req_fire;

   assign req_ready = !pend_vld_ff || push_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      pend_in        = pend_ff;
      pend_in.column = req_data.column;
      pend_in.value  = req_data.value;
      pend_in.col_ok = (int'(req_data.column) < glsq_pkg::MAX_UNKNOWNS);
      pend_in.action = glsq_pkg::action_type'(req_data.action);
      pend_vld_in = req_fire ? 1'b1 : (push_ready ? 1'b0 : pend_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
      end
      if (req_fire) begin
         pend_ff <= pend_in;
      end
   end

   assign push_valid = pend_vld_ff;
   assign push_data  = pend_ff;

endmodule
`default_nettype wire

### sv/glsq_fifo.sv
// Short queue of classified items between the front end and the back end.
`default_nettype none
module glsq_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire glsq_pkg::op_type  push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output glsq_pkg::op_type       pop_data
);

   localparam int PTR_W = (glsq_pkg::QUEUE_DEPTH > 1) ? $clog2(glsq_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(glsq_pkg::QUEUE_DEPTH + 1);

   glsq_pkg::op_type  entry_ff [glsq_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (int'(count_ff) < glsq_pkg::QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == glsq_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == glsq_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### sv/glsq_rootdiv.sv
// Shared serial unit: restoring division one bit per cycle, or integer square root
// two radicand bits per cycle.
`default_nettype none
module glsq_rootdiv (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire glsq_pkg::ru_req_type  req,
   output glsq_pkg::ru_stat_type      stat,
   output logic [63:0]                result
);

   localparam int DIV_STEPS  = 64;
   localparam int ROOT_STEPS = 32;

   logic        busy_ff, busy_in, done_ff, done_in, root_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] n_ff, n_in, acc_ff, acc_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] den_ff;
   logic [35:0] rem_sh, trial;
   logic        ge, last_step;

   always_comb begin
      rem_sh    = root_ff ? {rem_ff[33:0], n_ff[63:62]} : {rem_ff[34:0], n_ff[63]};
      trial     = root_ff ? {2'b00, acc_ff[31:0], 2'b01} : {4'b0000, den_ff};
      ge        = (rem_sh >= trial);
      last_step = root_ff ? (cnt_ff == 7'(ROOT_STEPS - 1)) : (cnt_ff == 7'(DIV_STEPS - 1));
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = req.num;
         rem_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - trial : rem_sh;
         acc_in  = {acc_ff[62:0], ge};
         n_in    = root_ff ? {n_ff[61:0], 2'b00} : {n_ff[62:0], 1'b0};
         cnt_in  = cnt_ff + 7'd1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      if (req.start) begin
         root_ff <= req.is_root;
         den_ff  <= req.den;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule
`default_nettype wire

### sv/glsq_back.sv
// Back end: sequencer that holds the factor and right-hand side, applies Givens
// rotations, back-substitutes and drives the result register.
`default_nettype none
module glsq_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [glsq_pkg::CNT_W-1:0]     order,
   input  wire logic                           pop_valid,
   output logic                                pop_ready,
   input  wire glsq_pkg::op_type               pop_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output glsq_pkg::rsp_type                   rsp_data
);

   localparam int N  = glsq_pkg::MAX_UNKNOWNS;
   localparam int IW = glsq_pkg::IDX_W;
   localparam int CW = glsq_pkg::CNT_W;
   localparam int AW = glsq_pkg::ADDR_W;

   typedef enum logic [21:0] {
      S_IDLE      = 22'h000001,
      S_COL       = 22'h000002,
      S_RII       = 22'h000004,
      S_SQ        = 22'h000008,
      S_SQADD     = 22'h000010,
      S_SQRT      = 22'h000020,
      S_DIVC      = 22'h000040,
      S_DIVS      = 22'h000080,
      S_ROW       = 22'h000100,
      S_ROWA      = 22'h000200,
      S_ROT       = 22'h000400,
      S_EMIT_RES  = 22'h000800,
      S_CHK       = 22'h001000,
      S_CHKD      = 22'h002000,
      S_DIAG      = 22'h004000,
      S_DIAGD     = 22'h008000,
      S_DIVW      = 22'h010000,
      S_BS        = 22'h020000,
      S_BSD       = 22'h040000,
      S_BSU       = 22'h080000,
      S_EMIT_W    = 22'h100000,
      S_EMIT_SING = 22'h200000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [2:0]         step_ff, step_in;
   logic               rot_rhs_ff, rot_rhs_in;
   logic signed [31:0] x_ff [N], x_in [N];
   logic signed [31:0] rhs_ff [N], rhs_in [N];
   logic signed [31:0] w_ff [N], w_in [N];
   logic signed [31:0] row_ff [N];
   logic signed [31:0] y_ff, y_in, xi_ff, xi_in, rii_ff, rii_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, s_ff, s_in, wi_ff, wi_in;
   logic [31:0]        d_ff, d_in;
   logic signed [63:0] t1_ff, t1_in, prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;

   // Triangle store: one write port, one registered read port, a valid bit per entry.
   logic signed [31:0] tri_mem [glsq_pkg::TRI_DEPTH];
   logic [glsq_pkg::TRI_DEPTH-1:0] tri_vld_ff, tri_vld_in;
   logic signed [31:0] rd_data_ff, tri_rd, wr_data;
   logic               rd_vld_ff, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;

   logic               rsp_valid_ff, rsp_valid_in, rsp_load, out_free;
   glsq_pkg::rsp_type  rsp_ff, rsp_in;

   glsq_pkg::ru_req_type  ru_req;
   glsq_pkg::ru_stat_type ru_stat;
   logic [63:0]           ru_result;

   logic [IW-1:0]      x_idx, w_idx;
   logic signed [31:0] x_rd, w_rd;
   logic signed [31:0] new_a, new_b;
   logic signed [63:0] q_signed;
   logic               clear_now;

   glsq_rootdiv u_rootdiv (
      .clock  (clock),
      .reset  (reset),
      .req    (ru_req),
      .stat   (ru_stat),
      .result (ru_result)
   );

   function automatic logic [AW-1:0] tri_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return {r[IW-1:0], c[IW-1:0]};
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == S_IDLE);
   assign tri_rd    = rd_vld_ff ? rd_data_ff : '0;
   assign x_idx     = (state_ff == S_COL) ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign w_idx     = (state_ff == S_DIAGD) ? i_ff[IW-1:0] : j_ff[IW-1:0];
   assign x_rd      = x_ff[x_idx];
   assign w_rd      = w_ff[w_idx];
   assign new_a     = glsq_pkg::sat_value(glsq_pkg::round_shift(t1_ff + prod_ff, 30));
   assign new_b     = glsq_pkg::sat_value(glsq_pkg::round_shift(t1_ff - prod_ff, 30));
   assign q_signed  = (a_ff[31] ^ rii_ff[31]) ? -$signed(ru_result) : $signed(ru_result);
   assign clear_now = (state_ff == S_IDLE) && pop_valid &&
                      (pop_data.action == glsq_pkg::ACT_CLEAR);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = a_ff;
      mul_b = c_ff;
      unique case (state_ff)
         S_RII: begin
            mul_a = tri_rd;
            mul_b = tri_rd;
         end
         S_SQ: begin
            mul_a = xi_ff;
            mul_b = xi_ff;
         end
         S_BSD: begin
            mul_a = tri_rd;
            mul_b = wi_ff;
         end
         S_ROT: begin
            unique case (step_ff)
               3'd1:    begin mul_a = b_ff; mul_b = s_ff; end
               3'd2:    begin mul_a = b_ff; mul_b = c_ff; end
               3'd3:    begin mul_a = a_ff; mul_b = s_ff; end
               default: begin mul_a = a_ff; mul_b = c_ff; end
            endcase
         end
         default: begin
            mul_a = a_ff;
            mul_b = c_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      step_in    = step_ff;
      rot_rhs_in = rot_rhs_ff;
      x_in       = x_ff;
      rhs_in     = rhs_ff;
      w_in       = w_ff;
      y_in       = y_ff;
      xi_in      = xi_ff;
      rii_in     = rii_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      s_in       = s_ff;
      wi_in      = wi_ff;
      d_in       = d_ff;
      t1_in      = t1_ff;
      prod_in    = mul_a * mul_b;
      tri_vld_in = tri_vld_ff;
      rd_addr    = tri_addr(i_ff, i_ff);
      wr_en      = 1'b0;
      wr_addr    = tri_addr(i_ff, i_ff);
      wr_data    = '0;
      rsp_load   = 1'b0;
      rsp_in     = rsp_ff;
      ru_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               unique case (pop_data.action)
                  glsq_pkg::ACT_OBS: begin
                     x_in     = row_ff;
                     y_in     = pop_data.value;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = S_COL;
                  end
                  glsq_pkg::ACT_SOLVE: begin
                     w_in     = rhs_ff;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = S_CHK;
                  end
                  glsq_pkg::ACT_CLEAR: begin
                     tri_vld_in = '0;
                     for (int k = 0; k < N; k++) begin
                        rhs_in[k] = '0;
                     end
                  end
                  default: begin
                     // Regressor elements are written to the row buffer below.
                  end
               endcase
            end
         end
         S_COL: begin
            if (i_ff == order) begin
               state_in = S_EMIT_RES;
            end else if (x_rd == '0) begin
               i_in = i_ff + CW'(1);
            end else begin
               xi_in    = x_rd;
               rd_addr  = tri_addr(i_ff, i_ff);
               state_in = S_RII;
            end
         end
         S_RII: begin
            rii_in   = tri_rd;
            state_in = S_SQ;
         end
         S_SQ: begin
            t1_in    = prod_ff;
            state_in = S_SQADD;
         end
         S_SQADD: begin
            ru_req.start   = 1'b1;
            ru_req.is_root = 1'b1;
            ru_req.num     = 64'(t1_ff) + 64'(prod_ff);
            state_in       = S_SQRT;
         end
         S_SQRT: begin
            if (ru_stat.done) begin
               d_in         = ru_result[31:0];
               ru_req.start = 1'b1;
               ru_req.num   = {2'b00, glsq_pkg::abs_value(rii_ff), 30'd0};
               ru_req.den   = ru_result[31:0];
               state_in     = S_DIVC;
            end
         end
         S_DIVC: begin
            if (ru_stat.done) begin
               c_in         = rii_ff[31] ? -$signed(ru_result[31:0]) : $signed(ru_result[31:0]);
               ru_req.start = 1'b1;
               ru_req.num   = {2'b00, glsq_pkg::abs_value(xi_ff), 30'd0};
               ru_req.den   = d_ff;
               state_in     = S_DIVS;
            end
         end
         S_DIVS: begin
            if (ru_stat.done) begin
               s_in     = xi_ff[31] ? -$signed(ru_result[31:0]) : $signed(ru_result[31:0]);
               wr_en    = 1'b1;
               wr_addr  = tri_addr(i_ff, i_ff);
               wr_data  = glsq_pkg::sat_value($signed({32'd0, d_ff}));
               j_in     = i_ff + CW'(1);
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            if (j_ff == order) begin
               a_in       = rhs_ff[i_ff[IW-1:0]];
               b_in       = y_ff;
               rot_rhs_in = 1'b1;
               step_in    = '0;
               state_in   = S_ROT;
            end else begin
               rd_addr  = tri_addr(i_ff, j_ff);
               state_in = S_ROWA;
            end
         end
         S_ROWA: begin
            a_in       = tri_rd;
            b_in       = x_rd;
            rot_rhs_in = 1'b0;
            step_in    = '0;
            state_in   = S_ROT;
         end
         S_ROT: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: begin
               end
               3'd1: t1_in = prod_ff;
               3'd2: begin
                  if (rot_rhs_ff) begin
                     rhs_in[i_ff[IW-1:0]] = new_a;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = tri_addr(i_ff, j_ff);
                     wr_data = new_a;
                  end
               end
               3'd3: t1_in = prod_ff;
               default: begin
                  if (rot_rhs_ff) begin
                     y_in     = new_b;
                     i_in     = i_ff + CW'(1);
                     state_in = S_COL;
                  end else begin
                     x_in[j_ff[IW-1:0]] = new_b;
                     j_in     = j_ff + CW'(1);
                     state_in = S_ROW;
                  end
               end
            endcase
         end
         S_EMIT_RES: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.kind         = glsq_pkg::KIND_RESIDUAL;
               rsp_in.index        = '0;
               rsp_in.result_value = y_ff;
               rsp_in.last         = 1'b1;
               rsp_in.singular     = 1'b0;
               state_in            = S_IDLE;
            end
         end
         S_CHK: begin
            if (i_ff == order) begin
               i_in     = order - CW'(1);
               state_in = S_DIAG;
            end else begin
               rd_addr  = tri_addr(i_ff, i_ff);
               state_in = S_CHKD;
            end
         end
         S_CHKD: begin
            if (tri_rd == '0) begin
               state_in = S_EMIT_SING;
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = S_CHK;
            end
         end
         S_DIAG: begin
            rd_addr  = tri_addr(i_ff, i_ff);
            state_in = S_DIAGD;
         end
         S_DIAGD: begin
            rii_in       = tri_rd;
            a_in         = w_rd;
            ru_req.start = 1'b1;
            ru_req.num   = {16'd0, glsq_pkg::abs_value(w_rd), 16'd0};
            ru_req.den   = glsq_pkg::abs_value(tri_rd);
            state_in     = S_DIVW;
         end
         S_DIVW: begin
            if (ru_stat.done) begin
               w_in[i_ff[IW-1:0]] = glsq_pkg::sat_value(q_signed);
               wi_in    = glsq_pkg::sat_value(q_signed);
               j_in     = '0;
               state_in = S_BS;
            end
         end
         S_BS: begin
            if (j_ff == i_ff) begin
               if (i_ff == '0) begin
                  j_in     = '0;
                  state_in = S_EMIT_W;
               end else begin
                  i_in     = i_ff - CW'(1);
                  state_in = S_DIAG;
               end
            end else begin
               rd_addr  = tri_addr(j_ff, i_ff);
               state_in = S_BSD;
            end
         end
         S_BSD: begin
            state_in = S_BSU;
         end
         S_BSU: begin
            w_in[j_ff[IW-1:0]] = glsq_pkg::sat_value(64'(w_rd) -
                                 glsq_pkg::round_shift(prod_ff, 16));
            j_in     = j_ff + CW'(1);
            state_in = S_BS;
         end
         S_EMIT_W: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.kind         = glsq_pkg::KIND_COEFF;
               rsp_in.index        = 3'(j_ff);
               rsp_in.result_value = w_rd;
               rsp_in.last         = (j_ff == order - CW'(1));
               rsp_in.singular     = 1'b0;
               j_in                = j_ff + CW'(1);
               if (j_ff == order - CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_SING: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_in.kind         = glsq_pkg::KIND_COEFF;
               rsp_in.index        = '0;
               rsp_in.result_value = '0;
               rsp_in.last         = 1'b1;
               rsp_in.singular     = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (wr_en) begin
         tri_vld_in[wr_addr] = 1'b1;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tri_vld_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         step_ff      <= '0;
         for (int k = 0; k < N; k++) begin
            rhs_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tri_vld_ff   <= tri_vld_in;
         rd_vld_ff    <= tri_vld_ff[rd_addr];
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         step_ff      <= step_in;
         rhs_ff       <= rhs_in;
      end
      rot_rhs_ff <= rot_rhs_in;
      x_ff       <= x_in;
      w_ff       <= w_in;
      y_ff       <= y_in;
      xi_ff      <= xi_in;
      rii_ff     <= rii_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      c_ff       <= c_in;
      s_ff       <= s_in;
      wi_ff      <= wi_in;
      d_ff       <= d_in;
      t1_ff      <= t1_in;
      prod_ff    <= prod_in;
      rd_data_ff <= tri_mem[rd_addr];
      if (wr_en) begin
         tri_mem[wr_addr] <= wr_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (state_ff == S_IDLE && pop_valid && pop_data.action == glsq_pkg::ACT_ELEM &&
          pop_data.col_ok) begin
         row_ff[IW'(pop_data.column)] <= pop_data.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_ru_start_idle: assert property (@(posedge clock) disable iff (reset)
      ru_req.start |-> !ru_stat.busy)
      else $error("root/divide unit restarted while busy");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten before transfer");
   a_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (i_ff <= order && j_ff <= order))
      else $error("row or column counter beyond order");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear_now |=> (tri_vld_ff == '0 && rhs_ff[0] == '0))
      else $error("clear did not empty the factor");
`endif

endmodule
`default_nettype wire

### sv/givens_qr_least_squares_top.sv
// Top level: order register, front end, item queue and back-end sequencer.
// The back end takes one item at a time and pops no new item until it is back in idle;
// observations and solves are paced by the shared serial root/divide unit, while element
// writes and clears are handled directly in the idle state.
// Reset is synchronous: factor and right-hand side read as zero, order returns to 8.
`default_nettype none
module givens_qr_least_squares_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire glsq_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output glsq_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [glsq_pkg::ORDER_W-1:0]       csr_data
);

   logic [glsq_pkg::ORDER_W-1:0] order_ff;
   logic [glsq_pkg::CNT_W-1:0]   order;
   logic                         push_valid, push_ready, pop_valid, pop_ready;
   glsq_pkg::op_type             push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= glsq_pkg::ORDER_RESET;
      end else if (csr_valid) begin
         order_ff <= csr_data;
      end
   end

   // An order of zero acts as one; values above the maximum act as the maximum.
   always_comb begin
      if (order_ff == '0) begin
         order = glsq_pkg::CNT_W'(1);
      end else if (int'(order_ff) > glsq_pkg::MAX_UNKNOWNS) begin
         order = glsq_pkg::CNT_W'(glsq_pkg::MAX_UNKNOWNS);
      end else begin
         order = glsq_pkg::CNT_W'(order_ff);
      end
   end

   glsq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   glsq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   glsq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .order     (order),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### verif/givens_qr_least_squares_top_tb.sv
// Testbench for the Givens QR least-squares block: directed and random traffic checked against a predictor.
`timescale 1ns / 1ps
module givens_qr_least_squares_top_tb;

   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint ONE_Q16 = 64'sd65536;
   localparam int WATCHDOG_LIMIT = 50000;
   localparam int DRAIN_CYCLES = 2000;
   localparam int LONG_HOLD = 3000;
   localparam int NU = glsq_pkg::MAX_UNKNOWNS;

   class lsq_scoreboard;
      longint tri_store[NU][NU];
      longint rhs[NU];
      longint row[NU];
      logic [glsq_pkg::ORDER_W-1:0] order;
      glsq_pkg::rsp_type expected_q[$];
      int errors;
      int residuals;
      int coeffs;
      int singulars;

      function new();
         foreach (tri_store[i, j]) tri_store[i][j] = 0;
         foreach (rhs[i]) rhs[i] = 0;
         foreach (row[i]) row[i] = 0;
         order = glsq_pkg::ORDER_RESET;
         errors = 0;
         residuals = 0;
         coeffs = 0;
         singulars = 0;
      endfunction

      function longint clip(longint v);
         if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return -64'sh8000_0000;
         return v;
      endfunction

      // Floor of p / 2^sh + 1/2.
      function longint round_half_up(longint p, int sh);
         return (p + (64'sd1 <<< (sh - 1))) >>> sh;
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned res;
         longint unsigned b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function int order_used();
         if (order == 0) return 1;
         if (order > NU) return NU;
         return int'(order);
      endfunction

      function longint rotate_row(longint y);
         longint x[NU];
         longint rii, xi, c, s, a, b;
         longint unsigned ar, ax, d;
         int q;
         q = order_used();
         x = row;
         for (int i = 0; i < q; i++) begin
            rii = tri_store[i][i];
            xi = x[i];
            if (xi == 0) continue;
            ar = (rii < 0) ? -rii : rii;
            ax = (xi < 0) ? -xi : xi;
            d = floor_root(ar * ar + ax * ax);
            c = (rii * ONE_Q30) / longint'(d);
            s = (xi * ONE_Q30) / longint'(d);
            tri_store[i][i] = clip(longint'(d));
            for (int j = i + 1; j < q; j++) begin
               a = tri_store[i][j];
               b = x[j];
               tri_store[i][j] = clip(round_half_up(a * c + b * s, 30));
               x[j] = clip(round_half_up(b * c - a * s, 30));
            end
            a = rhs[i];
            rhs[i] = clip(round_half_up(a * c + y * s, 30));
            y = clip(round_half_up(y * c - a * s, 30));
         end
         return y;
      endfunction

      function void push(logic kind, int idx, longint v, logic lst, logic sing);
         glsq_pkg::rsp_type e;
         e.kind = kind;
         e.index = 3'(idx);
         e.result_value = v[31:0];
         e.last = lst;
         e.singular = sing;
         expected_q.push_back(e);
      endfunction

      function void back_substitute();
         longint w[NU];
         int q;
         q = order_used();
         for (int i = 0; i < q; i++) begin
            if (tri_store[i][i] == 0) begin
               push(glsq_pkg::KIND_COEFF, 0, 0, 1'b1, 1'b1);
               singulars++;
               return;
            end
         end
         w = rhs;
         for (int i = q - 1; i >= 0; i--) begin
            w[i] = clip((w[i] * ONE_Q16) / tri_store[i][i]);
            for (int j = 0; j < i; j++)
               w[j] = clip(w[j] - round_half_up(tri_store[j][i] * w[i], 16));
         end
         for (int i = 0; i < q; i++) push(glsq_pkg::KIND_COEFF, i, w[i], i == q - 1, 1'b0);
         coeffs += q;
      endfunction

      function void note_request(glsq_pkg::req_type r);
         case (glsq_pkg::action_type'(r.action))
            glsq_pkg::ACT_ELEM: row[r.column] = longint'(r.value);
            glsq_pkg::ACT_OBS: begin
               push(glsq_pkg::KIND_RESIDUAL, 0, rotate_row(longint'(r.value)), 1'b1, 1'b0);
               residuals++;
            end
            glsq_pkg::ACT_SOLVE: back_substitute();
            default: begin
               foreach (tri_store[i, j]) tri_store[i][j] = 0;
               foreach (rhs[i]) rhs[i] = 0;
            end
         endcase
      endfunction

      function void check_response(glsq_pkg::rsp_type got);
         glsq_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.kind !== e.kind || got.index !== e.index || got.last !== e.last ||
             got.singular !== e.singular || got.result_value !== e.result_value) begin
            $display("%0t: result mismatch, expected kind %0d index %0d value %h last %0d sing %0d",
                     $realtime, e.kind, e.index, e.result_value, e.last, e.singular);
            $display("%0t:                   actual kind %0d index %0d value %h last %0d sing %0d",
                     $realtime, got.kind, got.index, got.result_value, got.last, got.singular);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   glsq_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   glsq_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [glsq_pkg::ORDER_W-1:0] csr_data = glsq_pkg::ORDER_RESET;

   lsq_scoreboard sb = new();
   bit calm = 1'b0;
   bit long_hold_req = 1'b0;
   int idle_cycles = 0;
   int items_sent = 0;

   givens_qr_least_squares_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.expected_q.size());
            $display("FAIL givens_qr_least_squares_top");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off so the block backs up.
   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $signed(32'($urandom_range(0, 2 * 262144))) - 32'sd262144;
      if (r < 70) return $signed(32'($urandom_range(0, 512))) - 32'sd256;
      if (r < 90) return $signed(32'($urandom));
      case ($urandom_range(0, 4))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sd0;
         3: return 32'sd1;
         default: return -32'sd1;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send(glsq_pkg::action_type act, int col, logic signed [31:0] v);
      glsq_pkg::req_type r;
      r.action = act;
      r.column = 3'(col);
      r.value = v;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      // Quiet items may still be in flight behind the last result.
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_order(logic [glsq_pkg::ORDER_W-1:0] q);
      csr_valid <= 1'b1;
      csr_data <= q;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.order = q;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_traffic(int n);
      int stop;
      int q;
      int r;
      stop = items_sent + n;
      q = sb.order_used();
      while (items_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            for (int c = 0; c < q; c++)
               if ($urandom_range(0, 4) != 0) send(glsq_pkg::ACT_ELEM, c, pick_value());
            send(glsq_pkg::ACT_OBS, $urandom_range(0, 7), pick_value());
         end else if (r < 85) begin
            send(glsq_pkg::ACT_SOLVE, $urandom_range(0, 7), pick_value());
         end else if (r < 90) begin
            send(glsq_pkg::ACT_CLEAR, $urandom_range(0, 7), pick_value());
         end else begin
            send(glsq_pkg::action_type'($urandom_range(0, 1)), $urandom_range(0, 7),
                 pick_value());
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: fill every column first, so no unwritten entry is ever read.
      write_order(4'd8);
      send(glsq_pkg::ACT_ELEM, 0, 32'sh7FFF_FFFF);
      send(glsq_pkg::ACT_ELEM, 1, 32'sh8000_0000);
      send(glsq_pkg::ACT_ELEM, 2, 32'sd0);
      send(glsq_pkg::ACT_ELEM, 3, 32'sd1);
      send(glsq_pkg::ACT_ELEM, 4, -32'sd1);
      send(glsq_pkg::ACT_ELEM, 5, 32'sh0001_0000);
      send(glsq_pkg::ACT_ELEM, 6, -32'sh0002_8000);
      send(glsq_pkg::ACT_ELEM, 7, 32'sh5555_AAAA);
      send(glsq_pkg::ACT_SOLVE, 0, 32'sd0);
      send(glsq_pkg::ACT_OBS, 7, 32'sh7FFF_FFFF);
      send(glsq_pkg::ACT_OBS, 0, 32'sh8000_0000);
      send(glsq_pkg::ACT_ELEM, 2, 32'sh0003_0000);
      send(glsq_pkg::ACT_OBS, 0, 32'sd0);
      send(glsq_pkg::ACT_SOLVE, 5, -32'sd1);
      send(glsq_pkg::ACT_CLEAR, 3, 32'sd7);
      send(glsq_pkg::ACT_SOLVE, 0, 32'sd0);
      send(glsq_pkg::ACT_ELEM, 0, 32'sd0);
      send(glsq_pkg::ACT_OBS, 0, -32'sd1);
      send(glsq_pkg::ACT_SOLVE, 7, 32'sh2AAA_5555);
      random_traffic(30);
      drain();

      write_order(4'd1);
      random_traffic(30);
      drain();
      write_order(4'd0);
      random_traffic(20);
      drain();
      write_order(4'd15);
      random_traffic(25);
      drain();

      // Receiver holds off for a long stretch while requests keep coming.
      write_order(4'd3);
      long_hold_req = 1'b1;
      random_traffic(40);
      drain();
      write_order(4'd5);
      random_traffic(40);
      drain();

      write_order(4'd8);
      calm = 1'b1;
      random_traffic(50);
      drain();

      $display("Sent %0d requests over orders 8, 1, 0, 15, 3, 5 and 8.", items_sent);
      $display("Checked %0d residuals, %0d coefficients and %0d singular solves.",
               sb.residuals, sb.coeffs, sb.singulars);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS givens_qr_least_squares_top");
      end else begin
         $display("FAIL givens_qr_least_squares_top");
      end
      $finish;
   end
endmodule
